>>> hw/rtl/asbt_pkg.sv
// shared types and constants for the address sorted block table
// no dependencies
package asbt_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned POS_W         = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_WR,
    S_RD_RD,
    S_RD_OUT
  } state_e;

  // one stored record
  typedef struct packed {
    logic [63:0]        address;
    logic [31:0]        size;
    logic [31:0]        tstamp;
    logic [1:0]         kind;
    logic signed [31:0] extra;
  } record_t;

endpackage

>>> hw/rtl/asbt_mem.sv
// record memory: one write port, one read port, registered read data
// depends on asbt_pkg
module asbt_mem #(
  parameter int unsigned DEPTH = asbt_pkg::DEFAULT_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  asbt_pkg::record_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output asbt_pkg::record_t rdata_o
);
  import asbt_pkg::*;

  record_t mem_q [DEPTH];
  record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/asbt_ctrl.sv
// sequencer: walks the record memory for insert, remove and read
// depends on asbt_pkg; drives asbt_mem
module asbt_ctrl #(
  parameter int unsigned DEPTH = asbt_pkg::DEFAULT_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  asbt_pkg::op_e                 op_i,
  input  asbt_pkg::record_t             rec_i,
  input  logic [asbt_pkg::POS_W-1:0]    pos_i,
  output logic                          busy_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output asbt_pkg::record_t             mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  asbt_pkg::record_t             mem_rdata_i,
  output logic                          res_valid_o,
  output asbt_pkg::status_e             res_status_o,
  output logic [asbt_pkg::COUNT_W-1:0]  res_count_o,
  output asbt_pkg::record_t             res_rec_o
);
  import asbt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        idx_q, idx_d;
  record_t              rec_q, rec_d;
  logic                 res_valid_q, res_valid_d;
  status_e              res_status_q, res_status_d;
  logic [COUNT_W-1:0]   res_count_q, res_count_d;
  record_t              res_rec_q, res_rec_d;

  logic                 accept;
  logic                 full;
  logic                 pos_bad;
  logic                 pos_last;
  logic                 ins_shift;
  logic                 idx_zero;
  logic                 rem_last;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        cnt_x;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic                 fin;
  status_e              fin_status;
  record_t              fin_rec;

  assign accept    = start_i && (state_q == S_IDLE);
  assign full      = (cnt_q == CW'(DEPTH));
  assign pos_x     = XW'(pos_i);
  assign cnt_x     = XW'(cnt_q);
  assign pos_bad   = (pos_x >= cnt_x);
  assign pos_last  = ((pos_x + XW'(1)) == cnt_x);
  // walking down from the tail: shift while the stored address is smaller
  assign ins_shift = (mem_rdata_i.address < rec_q.address);
  assign idx_zero  = (idx_q == AW'(1));
  assign rem_last  = ((CW'(idx_q) + CW'(2)) == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            OP_INSERT: if (!full && (cnt_q != '0)) state_d = S_INS_RD;
            OP_REMOVE: if (!pos_bad && !pos_last) state_d = S_REM_RD;
            OP_READ:   if (!pos_bad) state_d = S_RD_RD;
            OP_CLEAR:  state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD:  state_d = S_INS_WR;
      S_INS_WR: begin
        if (!ins_shift)    state_d = S_IDLE;
        else if (idx_zero) state_d = S_INS_PUT;
        else               state_d = S_INS_RD;
      end
      S_INS_PUT: state_d = S_IDLE;
      S_REM_RD:  state_d = S_REM_WR;
      S_REM_WR:  state_d = rem_last ? S_IDLE : S_REM_RD;
      S_RD_RD:   state_d = S_RD_OUT;
      S_RD_OUT:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = rec_q;
    mem_raddr_o = idx_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    rec_d       = rec_q;
    fin         = 1'b0;
    fin_status  = STAT_DONE;
    fin_rec     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rec_d = rec_i;
          unique case (op_i)
            OP_INSERT: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else if (cnt_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = rec_i;
                cnt_d       = CW'(1);
                fin         = 1'b1;
              end else begin
                idx_d = AW'(cnt_q);
              end
            end
            OP_REMOVE: begin
              idx_d = AW'(pos_x);
              if (pos_bad) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else if (pos_last) begin
                cnt_d = cnt_q - CW'(1);
                fin   = 1'b1;
              end
            end
            OP_READ: begin
              idx_d = AW'(pos_x);
              if (pos_bad) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
              fin   = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        mem_raddr_o = idx_q - AW'(1);
      end
      S_INS_WR: begin
        mem_we_o = 1'b1;
        if (ins_shift) begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q - AW'(1);
        end else begin
          cnt_d = cnt_q + CW'(1);
          fin   = 1'b1;
        end
      end
      S_INS_PUT: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + CW'(1);
        fin      = 1'b1;
      end
      S_REM_RD: begin
        mem_raddr_o = idx_q + AW'(1);
      end
      S_REM_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_q + AW'(1);
        if (rem_last) begin
          cnt_d = cnt_q - CW'(1);
          fin   = 1'b1;
        end
      end
      S_RD_RD: begin
        mem_raddr_o = idx_q;
      end
      S_RD_OUT: begin
        fin     = 1'b1;
        fin_rec = mem_rdata_i;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  always_comb begin
    res_valid_d  = fin;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_rec_d    = res_rec_q;
    if (fin) begin
      res_status_d = fin_status;
      res_count_d  = cnt_ext[COUNT_W-1:0];
      res_rec_d    = fin_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    rec_q        <= rec_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_rec_q    <= res_rec_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_count_o  = res_count_q;
  assign res_rec_o    = res_rec_q;

endmodule

>>> hw/rtl/address_sorted_block_table_top.sv
// top level of the address sorted block table
// depends on asbt_pkg, asbt_mem and asbt_ctrl
//
// channel   direction  handshake                  payload
// command   in         start_i high, busy_o low   op_i, new_*_i, position_i
// result    out        done_o high for one cycle  status_o, count_o, rd_*_o
//
// steps: clear, a full insert, an insert into an empty table, a remove of the
//   last record and an out-of-range position finish from idle; any other insert
//   reads and writes each record shifted toward the tail, then writes the new
//   record, in a step of its own when it lands at the head; a remove reads and
//   writes each record moved up, a read has a read step and an output step.
//   the single read port of the record memory moves one record per read/write pair.
// reset: rst_ni clears the sequencer and the record count; the records
//   themselves are not cleared, only positions below the count are read.
// stalls: the receiver cannot stall; each result word is shown for one
//   cycle, and the next command may be taken in that same cycle.
module address_sorted_block_table_top #(
  parameter int unsigned TABLE_DEPTH = asbt_pkg::DEFAULT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command word
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [63:0]        new_address_i,
  input  logic [31:0]        new_size_i,
  input  logic [31:0]        new_time_i,
  input  logic [1:0]         new_kind_i,
  input  logic signed [31:0] new_extra_i,
  input  logic [3:0]         position_i,
  // result word
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o,
  output logic [63:0]        rd_address_o,
  output logic [31:0]        rd_size_o,
  output logic [31:0]        rd_time_o,
  output logic [1:0]         rd_kind_o,
  output logic signed [31:0] rd_extra_o
);
  import asbt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  record_t        rec_in;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  record_t        mem_wdata;
  logic [AW-1:0]  mem_raddr;
  record_t        mem_rdata;
  status_e        res_status;
  record_t        res_rec;

  // pack the command fields into one record
  assign rec_in.address = new_address_i;
  assign rec_in.size    = new_size_i;
  assign rec_in.tstamp  = new_time_i;
  assign rec_in.kind    = new_kind_i;
  assign rec_in.extra   = new_extra_i;

  asbt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_e'(op_i)),
    .rec_i        (rec_in),
    .pos_i        (position_i),
    .busy_o       (busy_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (done_o),
    .res_status_o (res_status),
    .res_count_o  (count_o),
    .res_rec_o    (res_rec)
  );

  // records held in descending address order, position 0 at the head
  asbt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // read fields hold the record after a successful read and are zero after any other result
  assign status_o     = res_status;
  assign rd_address_o = res_rec.address;
  assign rd_size_o    = res_rec.size;
  assign rd_time_o    = res_rec.tstamp;
  assign rd_kind_o    = res_rec.kind;
  assign rd_extra_o   = res_rec.extra;

endmodule
